// File: rtl/elbc_pkg.sv
// ----------------------------------------------------------------------------
// elbc_pkg: shared types, constants and byte tables
// Exp/log tables (base 45 mod 257), key schedule constants and the bytewise
// dot and inverse dot helpers used by the round cells.
// ----------------------------------------------------------------------------
package elbc_pkg;

    localparam int unsigned DEF_ROUNDS = 12;
    localparam int unsigned REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

    localparam logic [63:0] SCHED_L_STEP = 64'h9e3779b97f4a7151;
    localparam logic [63:0] SCHED_K_INIT = 64'h8aed2a6bb7e15162;
    localparam logic [63:0] SCHED_K_STEP = 64'h7c159e3779b97f4a;

    // data carried from cell to cell
    typedef struct packed {
        logic        vld;
        logic        mode;
        logic [63:0] h;
        logic [63:0] l;
    } t_blk;

    // exp table, entry 128 (value 256) stored as zero
    function automatic logic [7:0] f_exp(input logic [7:0] i_x);
        logic [8:0] v;
        v = 9'd1;
        for (int k = 0; k < 256; k++) begin
            if (k[7:0] == i_x) begin
                return v[7:0];
            end
            v = 9'((17'(v) * 17'd45) % 17'd257);
        end
        return 8'd0;
    endfunction

    // constant lookup tables built at elaboration
    typedef logic [7:0] t_tab [256];

    function automatic t_tab f_build_exp();
        t_tab t;
        logic [8:0] v;
        v = 9'd1;
        for (int k = 0; k < 256; k++) begin
            t[k] = v[7:0];
            v = 9'((17'(v) * 17'd45) % 17'd257);
        end
        return t;
    endfunction

    function automatic t_tab f_build_log();
        t_tab t;
        t_tab e;
        e = f_build_exp();
        for (int k = 0; k < 256; k++) begin
            t[e[k]] = 8'(k);
        end
        return t;
    endfunction

    localparam t_tab EXP_TAB = f_build_exp();
    localparam t_tab LOG_TAB = f_build_log();

    function automatic logic [63:0] f_dot(input logic [63:0] i_b, input logic [63:0] i_c);
        logic [63:0] r;
        for (int j = 0; j < 8; j++) begin
            r[8*j +: 8] = EXP_TAB[i_b[8*j +: 8]] ^ EXP_TAB[i_c[8*j +: 8]];
        end
        return r;
    endfunction

    function automatic logic [63:0] f_inv_dot(input logic [63:0] i_a, input logic [63:0] i_c);
        logic [63:0] r;
        for (int j = 0; j < 8; j++) begin
            r[8*j +: 8] = LOG_TAB[i_a[8*j +: 8] ^ EXP_TAB[i_c[8*j +: 8]]];
        end
        return r;
    endfunction

endpackage

// File: rtl/elbc_sched_cell.sv
// ----------------------------------------------------------------------------
// elbc_sched_cell: one step of the key schedule recurrence
// Takes the running a/b sums and one (l, k) word pair, registers the new
// round key word and hands the sums to the next cell.
// ----------------------------------------------------------------------------
module elbc_sched_cell
    import elbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    input  logic [63:0] i_lw,
    input  logic [63:0] i_kw,
    output logic [63:0] o_a,
    output logic [63:0] o_b
);

    logic [63:0] n_a;
    logic [63:0] n_b;
    logic [63:0] w_s;
    logic [63:0] r_a;
    logic [63:0] r_b;

    // k step then l step with variable shift
    always_comb begin
        n_a = (i_kw + i_a + i_b) << 3;
        w_s = n_a + i_b;
        n_b = (i_lw + n_a + i_b) << w_s[5:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    assign o_a = r_a;
    assign o_b = r_b;

endmodule

// File: rtl/elbc_round_cell.sv
// ----------------------------------------------------------------------------
// elbc_round_cell: one cipher round as a two stage cell
// Stage one: encrypt key dot/add and mix start; stage two: mix end, decrypt
// key step; each round hands its neighbor a block every cycle i_en is high.
// ----------------------------------------------------------------------------
module elbc_round_cell
    import elbc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [3:0][63:0] i_ek,
    input  logic [3:0][63:0] i_dk,
    input  t_blk             i_blk,
    output t_blk             o_blk
);

    t_blk        r_s1;
    t_blk        r_s2;
    t_blk        n_s1;
    t_blk        n_s2;
    logic [63:0] r_t;
    logic [63:0] n_t;
    logic [63:0] w_y1;
    logic [63:0] w_y2;
    logic [63:0] w_z;
    logic [63:0] w_k2;
    logic [63:0] w_k3;

    // each stage picks its keys by the mode of the beat it holds
    assign w_k2 = i_blk.mode ? i_dk[2] : i_ek[2];
    assign w_k3 = r_s1.mode ? i_dk[3] : i_ek[3];

    // stage one: encrypt key step, then in both modes the first half of the mix
    always_comb begin
        n_s1 = i_blk;
        w_y1 = i_blk.h ^ i_blk.l;
        n_t  = f_dot(w_k2, w_y1);
        if (!i_blk.mode) begin
            n_s1.h = f_dot(i_blk.h, i_ek[0]);
            n_s1.l = i_blk.l + i_ek[1];
            n_t    = f_dot(w_k2, n_s1.h ^ n_s1.l);
        end
    end

    // stage two: finish the mix, then key step for decrypt
    always_comb begin
        n_s2 = r_s1;
        w_y2 = f_dot(r_t + (r_s1.h ^ r_s1.l), w_k3);
        w_z  = r_t + w_y2;
        n_s2.h = r_s1.h ^ w_z;
        n_s2.l = r_s1.l ^ w_z;
        if (r_s1.mode) begin
            n_s2.h = f_inv_dot(r_s1.h ^ w_z, i_dk[0]);
            n_s2.l = (r_s1.l ^ w_z) - i_dk[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
            r_s2.vld <= 1'b0;
        end else if (i_en) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_t  <= n_t;
        end
    end

    assign o_blk = r_s2;

endmodule

// File: rtl/exp_log_128bit_block_cipher.sv
// ----------------------------------------------------------------------------
// exp_log_128bit_block_cipher: pipelined 12-round exp/log block cipher
// Use: write key_high (index 0) and key_low (index 1) on the config port
// while idle. The first beat after a key change starts a schedule build:
// the schedule chain of 4*ROUNDS+3 cells is enabled until the round keys
// are latched, and that beat is held off until the schedule is ready.
// After that one beat (encrypt or decrypt by i_mode) is taken each cycle
// the row advances. A taken beat passes the entry register, the two stages
// of each round cell and the exit register before its result is offered;
// throughput is one block per cycle while the row advances, set by the row
// of round cells each passing a block to its neighbor every such cycle.
// The output register holds a finished beat while i_ready is low; the whole
// row stalls then, but input is still taken whenever the row can advance.
// Reset clears valids and marks the schedule as stale.
// ----------------------------------------------------------------------------
module exp_log_128bit_block_cipher
    import elbc_pkg::*;
#(
    parameter int unsigned ROUNDS = DEF_ROUNDS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_mode,
    input  logic [63:0]          i_block_high,
    input  logic [63:0]          i_block_low,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [63:0]          o_result_high,
    output logic [63:0]          o_result_low
);

    localparam int unsigned NKEYS = 4 * ROUNDS + 2;
    localparam int unsigned NWORK = 4 * ROUNDS + 4;
    localparam int unsigned CNT_W = $clog2(NWORK + 1);

    logic [63:0]      r_key_high;
    logic [63:0]      r_key_low;
    logic             r_sched_ok;
    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic             w_adv;
    logic             w_acc;
    logic [63:0]      w_sa [NWORK];
    logic [63:0]      w_sb [NWORK];
    logic [63:0]      w_lw [NWORK-1];
    logic [63:0]      w_kw [NWORK-1];
    logic [63:0]      r_rk [NKEYS];
    t_blk             w_c  [ROUNDS+1];
    t_blk             r_in;
    t_blk             n_in;
    t_blk             r_out;
    t_blk             n_out;

    // the row moves when the output slot is free or drains
    assign w_adv   = !r_out.vld || i_ready;
    assign o_ready = w_adv && r_sched_ok;
    assign w_acc   = i_valid && o_ready;

    // key registers and schedule control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_sched_ok <= 1'b0;
            r_busy     <= 1'b0;
            r_cnt      <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_KEY_HIGH) begin
                r_key_high <= i_cfg_data;
            end else begin
                r_key_low <= i_cfg_data;
            end
            r_sched_ok <= 1'b0;
            r_busy     <= 1'b0;
        end else if (!r_sched_ok && i_valid && !r_busy) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == CNT_W'(NWORK)) begin
                r_busy     <= 1'b0;
                r_sched_ok <= 1'b1;
            end
        end
    end

    // schedule words: closed forms of the two add recurrences
    always_comb begin
        w_lw[0] = r_key_high;
        w_kw[0] = SCHED_K_INIT;
        for (int i = 1; i < NWORK - 1; i++) begin
            w_lw[i] = (i == 1) ? r_key_low : r_key_low + 64'(i - 1) * SCHED_L_STEP;
            w_kw[i] = SCHED_K_INIT + 64'(i) * SCHED_K_STEP;
        end
    end

    assign w_sa[0] = '0;
    assign w_sb[0] = '0;

    // chain of schedule cells, each settles in the cycle after its neighbor
    for (genvar g = 0; g < NWORK - 1; g++) begin : g_sched
        elbc_sched_cell u_cell (
            .i_clk (i_clk),
            .i_en  (r_busy),
            .i_a   (w_sa[g]),
            .i_b   (w_sb[g]),
            .i_lw  (w_lw[g]),
            .i_kw  (w_kw[g]),
            .o_a   (w_sa[g+1]),
            .o_b   (w_sb[g+1])
        );
    end

    // round keys latched at the end of the build
    always_ff @(posedge i_clk) begin
        if (r_busy && r_cnt == CNT_W'(NWORK)) begin
            for (int i = 0; i < NKEYS; i++) begin
                r_rk[i] <= w_sa[i+2];
            end
        end
    end

    // entry stage: decrypt output transform is undone here
    always_comb begin
        n_in.vld  = w_acc;
        n_in.mode = i_mode;
        n_in.h    = i_block_high;
        n_in.l    = i_block_low;
        if (i_mode) begin
            n_in.h = f_inv_dot(i_block_high, r_rk[4*ROUNDS]);
            n_in.l = i_block_low - r_rk[4*ROUNDS+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in.vld <= 1'b0;
        end else if (w_adv) begin
            r_in <= n_in;
        end
    end

    assign w_c[0] = r_in;

    // round cells; decrypt walks the keys in reverse order
    for (genvar r = 0; r < ROUNDS; r++) begin : g_round
        logic [3:0][63:0] w_ek;
        logic [3:0][63:0] w_dk;
        always_comb begin
            for (int j = 0; j < 4; j++) begin
                w_ek[j] = r_rk[4*r+j];
                w_dk[j] = r_rk[4*(ROUNDS-1-r)+j];
            end
        end
        elbc_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_ek    (w_ek),
            .i_dk    (w_dk),
            .i_blk   (w_c[r]),
            .o_blk   (w_c[r+1])
        );
    end

    // exit stage: encrypt output transform
    always_comb begin
        n_out = w_c[ROUNDS];
        if (!w_c[ROUNDS].mode) begin
            n_out.h = f_dot(w_c[ROUNDS].h, r_rk[4*ROUNDS]);
            n_out.l = w_c[ROUNDS].l + r_rk[4*ROUNDS+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.vld <= 1'b0;
        end else if (w_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid       = r_out.vld;
    assign o_result_high = r_out.h;
    assign o_result_low  = r_out.l;

    // a held result beat stays valid and keeps its high half
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_result_high))
        else $error("result changed while stalled");

    // no input taken while the schedule is stale
    a_no_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_sched_ok |-> !o_ready)
        else $error("beat taken with stale schedule");

    // build does not run with a ready schedule
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !r_sched_ok)
        else $error("schedule build while ready");

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the exp/log 128-bit block cipher
// Drives blocks through the valid/ready stream under several keys and idle
// patterns, and checks every result beat against an in-bench model of the
// key schedule, the encrypt rounds and the decrypt rounds.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import elbc_pkg::*;

    localparam int NROUND = int'(DEF_ROUNDS);
    localparam int NRK    = 4 * NROUND + 2;
    localparam int NWK    = 4 * NROUND + 4;
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    typedef struct {
        logic [63:0] h;
        logic [63:0] l;
    } t_half_pair;

    typedef struct {
        logic        mode;
        logic [63:0] h;
        logic [63:0] l;
    } t_stim_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [REG_IDX_W-1:0] i_cfg_idx = REG_KEY_HIGH;
    logic [63:0]          i_cfg_data = '0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic                 i_mode = MODE_ENC;
    logic [63:0]          i_block_high = '0;
    logic [63:0]          i_block_low = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic [63:0]          o_result_high;
    logic [63:0]          o_result_low;

    exp_log_128bit_block_cipher DUT (.*);

    // clock, 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // cipher model state
    logic [7:0]  exp_byte [256];
    logic [7:0]  log_byte [256];
    logic [63:0] key_hi_m, key_lo_m;
    logic [63:0] rkey [NRK];
    bit          sched_ok;

    t_half_pair  expected_blocks [$];
    t_half_pair  cipher_pool [$];
    int          err_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    function automatic logic [63:0] exp_dot(logic [63:0] b, logic [63:0] c);
        logic [63:0] r;
        for (int j = 0; j < 8; j++)
            r[8*j +: 8] = exp_byte[b[8*j +: 8]] ^ exp_byte[c[8*j +: 8]];
        return r;
    endfunction

    function automatic logic [63:0] log_undot(logic [63:0] a, logic [63:0] c);
        logic [63:0] r;
        for (int j = 0; j < 8; j++)
            r[8*j +: 8] = log_byte[a[8*j +: 8] ^ exp_byte[c[8*j +: 8]]];
        return r;
    endfunction

    // add-and-shift key expansion
    task automatic expand_keys();
        logic [63:0] lw [NWK];
        logic [63:0] kw [NWK];
        logic [63:0] a, b, s;
        a = '0;
        b = '0;
        lw[0] = key_hi_m;
        lw[1] = key_lo_m;
        for (int i = 2; i < NWK; i++) lw[i] = lw[i-1] + SCHED_L_STEP;
        kw[0] = SCHED_K_INIT;
        for (int i = 1; i < NWK; i++) kw[i] = kw[i-1] + SCHED_K_STEP;
        for (int i = 0; i < NWK - 1; i++) begin
            kw[i] = (kw[i] + a + b) << 3;
            a = kw[i];
            s = a + b;
            lw[i] = (lw[i] + a + b) << s[5:0];
            b = lw[i];
        end
        for (int i = 0; i < NRK; i++) rkey[i] = kw[i+1];
        sched_ok = 1'b1;
    endtask

    function automatic logic [63:0] mix_z(logic [63:0] y1, int base);
        logic [63:0] t;
        t = exp_dot(rkey[base+2], y1);
        return t + exp_dot(t + y1, rkey[base+3]);
    endfunction

    task automatic cipher_block(input logic mode, input logic [63:0] hin,
                                input logic [63:0] lin, output t_half_pair res);
        logic [63:0] h, l, z;
        h = hin;
        l = lin;
        if (!sched_ok) expand_keys();
        if (mode == MODE_ENC) begin
            for (int r = 0; r < NROUND; r++) begin
                h = exp_dot(h, rkey[4*r]);
                l = l + rkey[4*r+1];
                z = mix_z(h ^ l, 4*r);
                h = h ^ z;
                l = l ^ z;
            end
            h = exp_dot(h, rkey[4*NROUND]);
            l = l + rkey[4*NROUND+1];
        end else begin
            h = log_undot(h, rkey[4*NROUND]);
            l = l - rkey[4*NROUND+1];
            for (int r = NROUND - 1; r >= 0; r--) begin
                z = mix_z(h ^ l, 4*r);
                h = h ^ z;
                l = l ^ z;
                h = log_undot(h, rkey[4*r]);
                l = l - rkey[4*r+1];
            end
        end
        res.h = h;
        res.l = l;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // key register write, model tracks the stale schedule
    task automatic write_key(input logic [REG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        if (idx == REG_KEY_HIGH) key_hi_m = val;
        else key_lo_m = val;
        sched_ok = 1'b0;
    endtask

    // one input beat, with random sender gaps before it
    task automatic send_block(input logic mode, input logic [63:0] h, input logic [63:0] l);
        t_half_pair res;
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid      <= 1'b1;
        i_mode       <= mode;
        i_block_high <= h;
        i_block_low  <= l;
        do @(posedge i_clk); while (!o_ready);
        cipher_block(mode, h, l, res);
        expected_blocks.push_back(res);
        if (mode == MODE_ENC) begin
            cipher_pool.push_back(res);
            if (cipher_pool.size() > 16) void'(cipher_pool.pop_front());
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (expected_blocks.size() != 0) @(posedge i_clk);
        repeat (2 * NROUND + 10) @(posedge i_clk);
    endtask

    // result beat check and receiver stalls
    always @(posedge i_clk) begin
        t_half_pair want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_blocks.size() == 0) begin
                $display("unexpected result beat %h %h at %0t",
                         o_result_high, o_result_low, $realtime);
                err_count++;
            end else begin
                want = expected_blocks.pop_front();
                if (o_result_high !== want.h) report_mismatch("result_high", o_result_high, want.h);
                if (o_result_low !== want.l) report_mismatch("result_low", o_result_low, want.l);
            end
        end
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // directed rows: extremes, exp entry 128 bytes, bit patterns
    t_stim_row dir_rows [] = '{
        '{MODE_ENC, 64'h0, 64'h0},
        '{MODE_DEC, 64'h0, 64'h0},
        '{MODE_ENC, '1, '1},
        '{MODE_DEC, '1, '1},
        '{MODE_ENC, 64'h8080808080808080, 64'h8080808080808080},
        '{MODE_DEC, 64'h8080808080808080, 64'h0},
        '{MODE_ENC, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa},
        '{MODE_DEC, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555},
        '{MODE_ENC, 64'h0000000000000001, 64'h8000000000000000},
        '{MODE_DEC, 64'h8000000000000000, 64'h0000000000000001},
        '{MODE_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210},
        '{MODE_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210},
        '{MODE_ENC, 64'h00000000ffffffff, 64'hffffffff00000000},
        '{MODE_DEC, 64'hff00ff00ff00ff00, 64'h00ff00ff00ff00ff}
    };

    initial begin
        logic [63:0] khi, klo;
        t_half_pair  pick;
        int          v;
        v = 1;
        for (int i = 0; i < 256; i++) begin
            exp_byte[i] = v[7:0];
            log_byte[v[7:0]] = i[7:0];
            v = (v * 45) % 257;
        end
        key_hi_m = '0;
        key_lo_m = '0;
        sched_ok = 1'b0;
        err_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on the reset key, first beat rebuilds the schedule
        foreach (dir_rows[i]) send_block(dir_rows[i].mode, dir_rows[i].h, dir_rows[i].l);
        drain();

        // key settings crossed with idle patterns
        for (int ks = 0; ks < 4; ks++) begin
            for (int im = 0; im < 4; im++) begin
                case (ks)
                    0: begin khi = '1; klo = '0; end
                    1: begin khi = '0; klo = '1; end
                    2: begin khi = '1; klo = '1; end
                    default: begin khi = {$urandom, $urandom}; klo = {$urandom, $urandom}; end
                endcase
                case (im)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 85; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 85; end
                    default: begin send_idle_pct = 33; recv_stall_pct = 33; end
                endcase
                // a single-register change also marks the schedule stale
                if (im == 1) write_key(REG_KEY_LOW, klo ^ 64'h1);
                else begin
                    write_key(REG_KEY_HIGH, khi);
                    write_key(REG_KEY_LOW, klo);
                end
                cipher_pool.delete();
                for (int n = 0; n < 105; n++) begin
                    if (cipher_pool.size() != 0 && $urandom_range(2) == 0) begin
                        // decrypt a recent ciphertext, should round-trip
                        pick = cipher_pool[$urandom_range(cipher_pool.size() - 1)];
                        send_block(MODE_DEC, pick.h, pick.l);
                    end else begin
                        send_block(1'($urandom_range(1)), {$urandom, $urandom},
                                   {$urandom, $urandom});
                    end
                end
                drain();
            end
        end

        if (err_count == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end

    // run time limit
    initial begin
        #5000000;
        $display("tb_top failed");
        $finish;
    end

endmodule
